/* hdl/wpp_pkg.sv */
package wpp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned RateW   = 32;
  localparam int unsigned ErrW    = 3;
  localparam int unsigned KindW   = 2;
  localparam int unsigned PosW    = 6;
  localparam int unsigned AsmW    = 24;
  localparam int unsigned SumW    = 25;
  localparam int unsigned OutDataW = 56;

  localparam logic [31:0] TagRiff = 32'h4646_4952;
  localparam logic [31:0] TagWave = 32'h4556_4157;
  localparam logic [31:0] TagFmt  = 32'h2074_6D66;
  localparam logic [31:0] TagData = 32'h6174_6164;

  localparam logic [PosW-1:0] PosRiff    = 6'd3;
  localparam logic [PosW-1:0] PosWave    = 6'd11;
  localparam logic [PosW-1:0] PosFmt     = 6'd15;
  localparam logic [PosW-1:0] PosFmtSize = 6'h13;
  localparam logic [PosW-1:0] PosEncode  = 6'h15;
  localparam logic [PosW-1:0] PosChannel = 6'h17;
  localparam logic [PosW-1:0] PosRate    = 6'h1B;
  localparam logic [PosW-1:0] PosBits    = 6'h23;
  localparam logic [PosW-1:0] PosTag     = 6'd3;
  localparam logic [PosW-1:0] PosSize    = 6'd7;

  localparam logic [31:0] MinFmtSize = 32'd16;
  localparam logic [15:0] EncPcm     = 16'd1;
  localparam logic [15:0] Bits16     = 16'd16;
  localparam logic [15:0] Bits24     = 16'd24;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_CHUNK_HDR,
    PH_DATA,
    PH_DONE,
    PH_FAILED
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [ErrW-1:0] {
    ERR_TAGS     = 3'd0,
    ERR_NOT_PCM  = 3'd1,
    ERR_CHANNELS = 3'd2,
    ERR_BITS     = 3'd3,
    ERR_DATA     = 3'd4
  } err_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    logic [SampleW-1:0] sample;
    logic [RateW-1:0]   rate;
    err_t               err;
  } res_t;

endpackage

/* hdl/wpp_parser.sv */
module wpp_parser (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [wpp_pkg::ByteW-1:0] file_byte,
  input  logic                      end_of_file,
  output wpp_pkg::res_t             res,
  output wpp_pkg::phase_t           phase
);

  wpp_pkg::phase_t               phase_next;
  logic [wpp_pkg::PosW-1:0]      byte_position, byte_position_next;
  logic [31:0]                   chunk_remaining, chunk_remaining_next;
  logic [31:0]                   field_shift, field_shift_next;
  logic [1:0]                    channel_count, channel_count_next;
  logic [1:0]                    bytes_per_sample, bytes_per_sample_next;
  logic [wpp_pkg::AsmW-1:0]      sample_assembly, sample_assembly_next;
  logic [1:0]                    byte_in_sample, byte_in_sample_next;
  logic                          channel_index, channel_index_next;
  logic signed [wpp_pkg::SumW-1:0] channel_sum, channel_sum_next;
  logic [31:0]                   held_rate, held_rate_next;
  logic                          tag_is_data, tag_is_data_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= wpp_pkg::PH_HEADER;
      byte_position    <= '0;
      chunk_remaining  <= '0;
      field_shift      <= '0;
      channel_count    <= '0;
      bytes_per_sample <= '0;
      sample_assembly  <= '0;
      byte_in_sample   <= '0;
      channel_index    <= 1'b0;
      channel_sum      <= '0;
      held_rate        <= '0;
      tag_is_data      <= 1'b0;
    end else if (en) begin
      phase            <= phase_next;
      byte_position    <= byte_position_next;
      chunk_remaining  <= chunk_remaining_next;
      field_shift      <= field_shift_next;
      channel_count    <= channel_count_next;
      bytes_per_sample <= bytes_per_sample_next;
      sample_assembly  <= sample_assembly_next;
      byte_in_sample   <= byte_in_sample_next;
      channel_index    <= channel_index_next;
      channel_sum      <= channel_sum_next;
      held_rate        <= held_rate_next;
      tag_is_data      <= tag_is_data_next;
    end
  end

  always_comb begin
    logic [wpp_pkg::AsmW-1:0]        asm_full;
    logic                            bps3;
    logic                            complete;
    logic signed [wpp_pkg::SumW-1:0] v;
    logic signed [wpp_pkg::SumW-1:0] sum;
    logic signed [wpp_pkg::SumW-1:0] avg;
    logic [15:0]                     hi16;

    phase_next            = phase;
    byte_position_next    = byte_position;
    chunk_remaining_next  = chunk_remaining;
    field_shift_next      = {file_byte, field_shift[31:8]};
    channel_count_next    = channel_count;
    bytes_per_sample_next = bytes_per_sample;
    sample_assembly_next  = sample_assembly;
    byte_in_sample_next   = byte_in_sample;
    channel_index_next    = channel_index;
    channel_sum_next      = channel_sum;
    held_rate_next        = held_rate;
    tag_is_data_next      = tag_is_data;
    res                   = '0;
    hi16                  = field_shift_next[31:16];

    unique case (byte_in_sample)
      2'd0:    asm_full = sample_assembly | {16'd0, file_byte};
      2'd1:    asm_full = sample_assembly | {8'd0, file_byte, 8'd0};
      default: asm_full = sample_assembly | {file_byte, 16'd0};
    endcase
    bps3     = (bytes_per_sample == 2'd3);
    complete = bps3 ? (byte_in_sample == 2'd2) : (byte_in_sample != 2'd0);
    v        = bps3 ? {asm_full[23], asm_full}
                    : {{9{asm_full[15]}}, asm_full[15:0]};
    sum      = channel_sum + v;
    if (channel_count == 2'd2) begin
      avg = (sum + {{(wpp_pkg::SumW-1){1'b0}}, sum[wpp_pkg::SumW-1]}) >>> 1;
    end else begin
      avg = sum;
    end
    if (bps3) begin
      avg = avg >>> 8;
    end

    unique case (phase)
      wpp_pkg::PH_HEADER: begin
        byte_position_next = byte_position + 1'b1;
        priority if (byte_position == wpp_pkg::PosRiff && field_shift_next != wpp_pkg::TagRiff)
        begin
          res.valid = 1'b1; res.kind = wpp_pkg::KIND_ERROR; res.err = wpp_pkg::ERR_TAGS;
          phase_next = wpp_pkg::PH_FAILED;
        end else if (byte_position == wpp_pkg::PosWave
                     && field_shift_next != wpp_pkg::TagWave) begin
          res.valid = 1'b1; res.kind = wpp_pkg::KIND_ERROR; res.err = wpp_pkg::ERR_TAGS;
          phase_next = wpp_pkg::PH_FAILED;
        end else if (byte_position == wpp_pkg::PosFmt
                     && field_shift_next != wpp_pkg::TagFmt) begin
          res.valid = 1'b1; res.kind = wpp_pkg::KIND_ERROR; res.err = wpp_pkg::ERR_TAGS;
          phase_next = wpp_pkg::PH_FAILED;
        end else if (byte_position == wpp_pkg::PosFmtSize) begin
          if (field_shift_next < wpp_pkg::MinFmtSize) begin
            res.valid = 1'b1; res.kind = wpp_pkg::KIND_ERROR; res.err = wpp_pkg::ERR_TAGS;
            phase_next = wpp_pkg::PH_FAILED;
          end else begin
            chunk_remaining_next = field_shift_next - wpp_pkg::MinFmtSize;
          end
        end else if (byte_position == wpp_pkg::PosEncode && hi16 != wpp_pkg::EncPcm) begin
          res.valid = 1'b1; res.kind = wpp_pkg::KIND_ERROR; res.err = wpp_pkg::ERR_NOT_PCM;
          phase_next = wpp_pkg::PH_FAILED;
        end else if (byte_position == wpp_pkg::PosChannel) begin
          if (hi16 != 16'd1 && hi16 != 16'd2) begin
            res.valid = 1'b1; res.kind = wpp_pkg::KIND_ERROR;
            res.err = wpp_pkg::ERR_CHANNELS;
            phase_next = wpp_pkg::PH_FAILED;
          end else begin
            channel_count_next = hi16[1:0];
          end
        end else if (byte_position == wpp_pkg::PosRate) begin
          held_rate_next = field_shift_next;
        end else if (byte_position == wpp_pkg::PosBits) begin
          if (hi16 != wpp_pkg::Bits16 && hi16 != wpp_pkg::Bits24) begin
            res.valid = 1'b1; res.kind = wpp_pkg::KIND_ERROR; res.err = wpp_pkg::ERR_BITS;
            phase_next = wpp_pkg::PH_FAILED;
          end else begin
            bytes_per_sample_next = (hi16 == wpp_pkg::Bits24) ? 2'd3 : 2'd2;
            res.valid = 1'b1; res.kind = wpp_pkg::KIND_FORMAT; res.rate = held_rate;
            byte_position_next = '0;
            phase_next = (chunk_remaining != '0) ? wpp_pkg::PH_SKIP
                                                 : wpp_pkg::PH_CHUNK_HDR;
          end
        end else begin
        end
      end
      wpp_pkg::PH_SKIP: begin
        chunk_remaining_next = chunk_remaining - 1'b1;
        if (chunk_remaining_next == '0) begin
          phase_next         = wpp_pkg::PH_CHUNK_HDR;
          byte_position_next = '0;
        end
      end
      wpp_pkg::PH_CHUNK_HDR: begin
        byte_position_next = byte_position + 1'b1;
        if (byte_position == wpp_pkg::PosTag) begin
          tag_is_data_next = (field_shift_next == wpp_pkg::TagData);
        end
        if (byte_position == wpp_pkg::PosSize) begin
          byte_position_next   = '0;
          chunk_remaining_next = field_shift_next;
          if (tag_is_data) begin
            sample_assembly_next = '0;
            byte_in_sample_next  = '0;
            channel_index_next   = 1'b0;
            channel_sum_next     = '0;
            phase_next = (field_shift_next != '0) ? wpp_pkg::PH_DATA : wpp_pkg::PH_DONE;
          end else begin
            phase_next = (field_shift_next != '0) ? wpp_pkg::PH_SKIP
                                                  : wpp_pkg::PH_CHUNK_HDR;
          end
        end
      end
      wpp_pkg::PH_DATA: begin
        chunk_remaining_next = chunk_remaining - 1'b1;
        if (complete) begin
          sample_assembly_next = '0;
          byte_in_sample_next  = '0;
          if (channel_count != 2'd2 || channel_index) begin
            res.valid          = 1'b1;
            res.kind           = wpp_pkg::KIND_SAMPLE;
            res.sample         = avg[wpp_pkg::SampleW-1:0];
            channel_sum_next   = '0;
            channel_index_next = 1'b0;
          end else begin
            channel_sum_next   = sum;
            channel_index_next = 1'b1;
          end
        end else begin
          sample_assembly_next = asm_full;
          byte_in_sample_next  = byte_in_sample + 1'b1;
        end
        if (chunk_remaining_next == '0) begin
          phase_next = wpp_pkg::PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (end_of_file) begin
      if (phase_next == wpp_pkg::PH_HEADER || phase_next == wpp_pkg::PH_SKIP
          || phase_next == wpp_pkg::PH_CHUNK_HDR || phase_next == wpp_pkg::PH_DATA) begin
        res       = '0;
        res.valid = 1'b1;
        res.kind  = wpp_pkg::KIND_ERROR;
        res.err   = wpp_pkg::ERR_DATA;
      end
      phase_next            = wpp_pkg::PH_HEADER;
      byte_position_next    = '0;
      chunk_remaining_next  = '0;
      field_shift_next      = '0;
      channel_count_next    = '0;
      bytes_per_sample_next = '0;
      sample_assembly_next  = '0;
      byte_in_sample_next   = '0;
      channel_index_next    = 1'b0;
      channel_sum_next      = '0;
      held_rate_next        = '0;
      tag_is_data_next      = 1'b0;
    end
  end

endmodule

/* hdl/wav_pcm_parse_mono_downmix_core.sv */
// A result word is registered: it appears on m_tvalid in the cycle after the file byte is taken.
// Throughput: one file byte per cycle while s_tready is high; the parser state updates on each
// taken byte, and the output register frees s_tready whenever it is empty or being drained.
// Reset: rst is synchronous, active high; it returns the parser to the RIFF header
// and empties the output register. The byte marked s_tlast also restarts the parser.
module wav_pcm_parse_mono_downmix_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [wpp_pkg::ByteW-1:0]    s_tdata,   // [7:0] file_byte
  input  logic                         s_tlast,   // end_of_file
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [wpp_pkg::OutDataW-1:0] m_tdata,   // [15:0] mono_sample, [47:16] sample_rate,
                                                  // [50:48] error_code, [55:51] zero
  output logic [wpp_pkg::KindW-1:0]    m_tuser    // [1:0] result_kind
);

  wpp_pkg::res_t   res;
  wpp_pkg::phase_t phase;
  logic            accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  wpp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .en          (accept),
    .file_byte   (s_tdata),
    .end_of_file (s_tlast),
    .res         (res),
    .phase       (phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      m_tdata <= {5'd0, res.err, res.rate, res.sample};
      m_tuser <= res.kind;
    end
  end

`ifndef SYNTHESIS
  a_eof_restarts: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> phase == wpp_pkg::PH_HEADER)
    else $error("parser did not restart after end of file");

  a_sample_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == wpp_pkg::KIND_SAMPLE |-> m_tdata[55:16] == '0)
    else $error("sample word carries rate or error bits");

  a_no_kind3: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("undefined result kind");

  a_format_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == wpp_pkg::KIND_FORMAT |-> m_tdata[15:0] == '0
      && m_tdata[55:48] == '0)
    else $error("format word carries sample or error bits");
`endif

endmodule

/* tb/tb_wav_pcm_parse_mono_downmix_core.sv */
`timescale 1ns / 100ps

module tb_wav_pcm_parse_mono_downmix_core;
  import wpp_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int CalmTail   = 80;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_word_t;

  typedef struct packed {
    kind_t              kind;
    logic [SampleW-1:0] sample;
    logic [RateW-1:0]   rate;
    err_t               err;
  } wav_res_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic [KindW-1:0]    m_tuser;

  wav_pcm_parse_mono_downmix_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  file_word_t words_to_send[$];
  wav_res_t   expected_results[$];
  logic [7:0] wav_buf[$];
  int         mismatches   = 0;
  int         cycle_count  = 0;
  int         bytes_taken  = 0;
  logic       calm         = 1'b0;
  logic       backlog_hold = 1'b0;
  logic       backlog_done = 1'b0;
  int         backlog_left = 0;

  // parser shadow state
  phase_t      ps_phase;
  logic [31:0] ps_pos;
  logic [31:0] ps_left;
  logic [31:0] ps_window;
  logic [31:0] ps_rate;
  logic [1:0]  ps_chans;
  logic [1:0]  ps_bps;
  logic [31:0] ps_asm;
  logic [1:0]  ps_nbyte;
  logic        ps_second;
  int          ps_sum;
  logic        ps_tag_data;

  task automatic parse_reset();
    ps_phase    = PH_HEADER;
    ps_pos      = '0;
    ps_left     = '0;
    ps_window   = '0;
    ps_rate     = '0;
    ps_chans    = '0;
    ps_bps      = '0;
    ps_asm      = '0;
    ps_nbyte    = '0;
    ps_second   = 1'b0;
    ps_sum      = 0;
    ps_tag_data = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eof);
    logic [31:0] pos;
    logic [15:0] hi;
    int          v;
    int          avg;
    int          nb;
    logic        hit;
    logic        failed;
    err_t        fe;
    wav_res_t    r;
    hit       = 1'b0;
    failed    = 1'b0;
    fe        = ERR_TAGS;
    r         = '{KIND_SAMPLE, 16'h0, 32'h0, ERR_TAGS};
    ps_window = {b, ps_window[31:8]};
    hi        = ps_window[31:16];
    case (ps_phase)
      PH_HEADER: begin
        pos    = ps_pos;
        ps_pos = ps_pos + 1;
        if (pos == PosRiff && ps_window != TagRiff) begin
          failed = 1'b1;
          fe = ERR_TAGS;
        end else if (pos == PosWave && ps_window != TagWave) begin
          failed = 1'b1;
          fe = ERR_TAGS;
        end else if (pos == PosFmt && ps_window != TagFmt) begin
          failed = 1'b1;
          fe = ERR_TAGS;
        end else if (pos == PosFmtSize) begin
          if (ps_window < MinFmtSize) begin
            failed = 1'b1;
            fe = ERR_TAGS;
          end else begin
            ps_left = ps_window - MinFmtSize;
          end
        end else if (pos == PosEncode && hi != EncPcm) begin
          failed = 1'b1;
          fe = ERR_NOT_PCM;
        end else if (pos == PosChannel) begin
          if (hi != 16'd1 && hi != 16'd2) begin
            failed = 1'b1;
            fe = ERR_CHANNELS;
          end else begin
            ps_chans = hi[1:0];
          end
        end else if (pos == PosRate) begin
          ps_rate = ps_window;
        end else if (pos == PosBits) begin
          if (hi != Bits16 && hi != Bits24) begin
            failed = 1'b1;
            fe = ERR_BITS;
          end else begin
            ps_bps   = (hi == Bits24) ? 2'd3 : 2'd2;
            hit      = 1'b1;
            r.kind   = KIND_FORMAT;
            r.rate   = ps_rate;
            ps_pos   = '0;
            ps_phase = (ps_left != 0) ? PH_SKIP : PH_CHUNK_HDR;
          end
        end
      end
      PH_SKIP: begin
        ps_left = ps_left - 1;
        if (ps_left == 0) begin
          ps_phase = PH_CHUNK_HDR;
          ps_pos   = '0;
        end
      end
      PH_CHUNK_HDR: begin
        pos    = ps_pos;
        ps_pos = ps_pos + 1;
        if (pos == PosTag) ps_tag_data = (ps_window == TagData);
        if (pos >= PosSize) begin
          ps_pos  = '0;
          ps_left = ps_window;
          if (ps_tag_data) begin
            ps_asm    = '0;
            ps_nbyte  = '0;
            ps_second = 1'b0;
            ps_sum    = 0;
            ps_phase  = (ps_window != 0) ? PH_DATA : PH_DONE;
          end else begin
            ps_phase  = (ps_window != 0) ? PH_SKIP : PH_CHUNK_HDR;
          end
        end
      end
      PH_DATA: begin
        nb       = (ps_bps == 2'd3) ? 3 : 2;
        ps_asm   = ps_asm | (32'(b) << (8 * ps_nbyte));
        ps_nbyte = ps_nbyte + 2'd1;
        ps_left  = ps_left - 1;
        if (ps_nbyte >= nb) begin
          if (nb == 3) v = 32'($signed(ps_asm[23:0]));
          else v = 32'($signed(ps_asm[15:0]));
          ps_sum   = ps_sum + v;
          ps_asm   = '0;
          ps_nbyte = '0;
          if (ps_chans != 2'd2 || ps_second) begin
            avg = (ps_chans == 2'd2) ? ps_sum / 2 : ps_sum;
            if (nb == 3) avg = avg >>> 8;
            hit       = 1'b1;
            r.kind    = KIND_SAMPLE;
            r.sample  = avg[15:0];
            ps_sum    = 0;
            ps_second = 1'b0;
          end else begin
            ps_second = 1'b1;
          end
        end
        if (ps_left == 0) ps_phase = PH_DONE;
      end
      default: ;
    endcase
    if (failed) ps_phase = PH_FAILED;
    if (eof && ps_phase != PH_DONE && ps_phase != PH_FAILED) begin
      failed = 1'b1;
      fe = ERR_DATA;
    end
    if (failed) begin
      r   = '{KIND_ERROR, 16'h0, 32'h0, fe};
      hit = 1'b1;
    end
    if (eof) parse_reset();
    if (hit) expected_results.push_back(r);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) wav_buf.push_back(v[8*i +: 8]);
  endtask

  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] size);
    put_le(tag, 4);
    put_le(size, 4);
  endtask

  task automatic put_fmt(input logic [31:0] fmt_size, input logic [15:0] enc,
                         input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] bits, input int ext);
    put_le(TagRiff, 4);
    put_le($urandom, 4);
    put_le(TagWave, 4);
    put_le(TagFmt, 4);
    put_le(fmt_size, 4);
    put_le(32'(enc), 2);
    put_le(32'(chans), 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(32'(bits), 2);
    repeat (ext) put_le($urandom, 1);
  endtask

  task automatic put_samples(input int n);
    logic [7:0] v;
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: v = 8'h00;
        1: v = 8'hFF;
        2: v = 8'h80;
        3: v = 8'h7F;
        default: v = 8'($urandom);
      endcase
      wav_buf.push_back(v);
    end
  endtask

  task automatic ship();
    file_word_t w;
    foreach (wav_buf[i]) begin
      w.data = wav_buf[i];
      w.last = (i == wav_buf.size() - 1);
      words_to_send.push_back(w);
    end
    wav_buf.delete();
  endtask

  // sender
  int         send_gap = 0;
  logic       nx_valid;
  file_word_t nx_word;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      nx_valid = s_tvalid;
      nx_word  = '{s_tdata, s_tlast};
      if (s_tvalid && s_tready) begin
        parse_byte(s_tdata, s_tlast);
        bytes_taken <= bytes_taken + 1;
        nx_valid = 1'b0;
      end
      if (!nx_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (words_to_send.size() > 0) begin
          if (words_to_send.size() > CalmTail && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 16);
          end else begin
            nx_word  = words_to_send.pop_front();
            nx_valid = 1'b1;
          end
        end
      end
      s_tvalid <= nx_valid;
      s_tdata  <= nx_word.data;
      s_tlast  <= nx_word.last;
      calm     <= (words_to_send.size() <= CalmTail);
    end
  end

  // long receiver hold so the output register fills and the input stalls
  always @(posedge clk) begin
    if (rst) begin
      backlog_hold <= 1'b0;
    end else if (!backlog_done && bytes_taken >= 300) begin
      backlog_hold <= 1'b1;
      backlog_done <= 1'b1;
      backlog_left <= 400;
    end else if (backlog_left > 0) begin
      backlog_left <= backlog_left - 1;
      if (backlog_left == 1) backlog_hold <= 1'b0;
    end
  end

  // receiver and checker
  int       rcv_gap = 0;
  logic     take;
  wav_res_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no word, got kind %0d data %h", $time, m_tuser, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (m_tuser !== want.kind || m_tdata[15:0] !== want.sample ||
              m_tdata[47:16] !== want.rate || m_tdata[50:48] !== want.err ||
              m_tdata[55:51] !== 5'd0) begin
            mismatches++;
            $display("%0t: expected kind %0d sample %h rate %h err %0d,",
                     $time, want.kind, want.sample, want.rate, want.err,
                     " got kind %0d sample %h rate %h err %0d pad %h",
                     m_tuser, m_tdata[15:0], m_tdata[47:16], m_tdata[50:48],
                     m_tdata[55:51]);
          end
        end
      end
      if (rcv_gap > 0) begin
        rcv_gap--;
        take = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rcv_gap = $urandom_range(0, 16);
        take = 1'b0;
      end else begin
        take = 1'b1;
      end
      m_tready <= take && !backlog_hold;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  int          bad_at[3] = '{0, 11, 12};
  int          rnd_bytes = 0;
  int          sel;
  int          ext;
  int          csz;
  int          dsz;
  logic [15:0] enc;
  logic [15:0] nch;
  logic [15:0] nbits;
  logic [31:0] tag;

  initial begin
    parse_reset();

    // mono 16-bit, sample range extremes, file ends on the last data byte
    put_fmt(32'd16, EncPcm, 16'd1, 32'd0, Bits16, 0);
    put_chunk(TagData, 32'd8);
    put_le(32'h8000, 2); put_le(32'h7FFF, 2); put_le(32'hFFFF, 2); put_le(32'h0000, 2);
    ship();
    // stereo 16-bit: extended fmt, odd chunk to skip, partial frame, trailing bytes
    put_fmt(32'd18, EncPcm, 16'd2, 32'hFFFF_FFFF, Bits16, 2);
    put_chunk(32'h5453_494C, 32'd3); put_le(32'h00AA_55FF, 3);
    put_chunk(TagData, 32'd18);
    put_le(32'h0000_FFFF, 4); put_le(32'h8000_8000, 4);
    put_le(32'h7FFF_7FFF, 4); put_le(32'h0000_FFFD, 4);
    put_le(32'h1234, 2); put_le(32'h00FF_FFFF, 3);
    ship();
    // mono 24-bit with a dropped partial sample
    put_fmt(32'd16, EncPcm, 16'd1, 32'd44100, Bits24, 0);
    put_chunk(TagData, 32'd13);
    put_le(32'h80_0000, 3); put_le(32'h7F_FFFF, 3); put_le(32'hFF_FFFF, 3);
    put_le(32'h00_00FF, 3); put_le(32'h5A, 1);
    ship();
    // stereo 24-bit
    put_fmt(32'd16, EncPcm, 16'd2, 32'd48000, Bits24, 0);
    put_chunk(TagData, 32'd24);
    put_le(32'h80_0000, 3); put_le(32'h80_0000, 3);
    put_le(32'hFF_FFFF, 3); put_le(32'h00_0000, 3);
    put_le(32'hFF_FFFD, 3); put_le(32'h00_0000, 3);
    put_le(32'h7F_FFFF, 3); put_le(32'h7F_FFFF, 3);
    ship();
    // zero-size chunk, empty data chunk, bytes after the data
    put_fmt(32'd16, EncPcm, 16'd1, 32'd8000, Bits16, 0);
    put_chunk(32'h6B6E_756A, 32'd0);
    put_chunk(TagData, 32'd0);
    put_le($urandom, 4);
    ship();
    // bad RIFF, WAVE and fmt tags, a few ignored bytes after each
    foreach (bad_at[i]) begin
      put_fmt(32'd16, EncPcm, 16'd1, 32'd0, Bits16, 0);
      wav_buf[bad_at[i]] = wav_buf[bad_at[i]] ^ 8'h20;
      wav_buf = wav_buf[0:bad_at[i] + 6];
      ship();
    end
    // short fmt chunk, bad encodings, bad channel counts, bad widths
    put_fmt(32'd15, EncPcm, 16'd1, 32'd0, Bits16, 0); wav_buf = wav_buf[0:21]; ship();
    put_fmt(32'd16, 16'd3, 16'd1, 32'd0, Bits16, 0); wav_buf = wav_buf[0:23]; ship();
    put_fmt(32'd16, 16'h0101, 16'd1, 32'd0, Bits16, 0); wav_buf = wav_buf[0:23]; ship();
    put_fmt(32'd16, EncPcm, 16'd0, 32'd0, Bits16, 0); wav_buf = wav_buf[0:25]; ship();
    put_fmt(32'd16, EncPcm, 16'd3, 32'd0, Bits16, 0); wav_buf = wav_buf[0:25]; ship();
    put_fmt(32'd16, EncPcm, 16'hFFFF, 32'd0, Bits16, 0); wav_buf = wav_buf[0:25]; ship();
    put_fmt(32'd16, EncPcm, 16'd1, 32'd0, 16'hFFFF, 0); put_samples(2); ship();
    // bad width found on the final byte of the file
    put_fmt(32'd16, EncPcm, 16'd2, 32'd0, 16'd8, 0); ship();
    // early ends: inside the header, on the format byte, while skipping,
    // in a chunk header, in a huge data chunk, on a frame-completing byte
    put_fmt(32'd16, EncPcm, 16'd1, 32'd0, Bits16, 0); wav_buf = wav_buf[0:9]; ship();
    put_fmt(32'd16, EncPcm, 16'd1, 32'd22050, Bits16, 0); ship();
    put_fmt(32'hFFFF_FFFF, EncPcm, 16'd2, 32'd0, Bits24, 5); ship();
    put_fmt(32'd16, EncPcm, 16'd2, 32'd0, Bits16, 0);
    put_chunk(TagData, 32'd8); void'(wav_buf.pop_back()); ship();
    put_fmt(32'd16, EncPcm, 16'd2, 32'd0, Bits16, 0);
    put_chunk(TagData, 32'hFFFF_FFFF); put_samples(6); ship();
    put_fmt(32'd16, EncPcm, 16'd1, 32'd0, Bits16, 0);
    put_chunk(TagData, 32'd8); put_samples(4); ship();

    // random files: mostly well formed, some noise, corrupted or cut short
    while (rnd_bytes < 100) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        repeat ($urandom_range(1, 60)) wav_buf.push_back(8'($urandom));
      end else begin
        ext   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        enc   = EncPcm;
        nch   = 16'($urandom_range(1, 2));
        nbits = $urandom_range(0, 1) ? Bits24 : Bits16;
        if (sel == 3) begin
          enc   = 16'($urandom_range(0, 2));
          nch   = 16'($urandom_range(0, 3));
          nbits = 16'(8 * $urandom_range(1, 4));
        end
        put_fmt(32'd16 + ext, enc, nch, $urandom, nbits, ext);
        repeat ($urandom_range(0, 2)) begin
          tag = $urandom_range(0, 1) ? $urandom : TagData ^ (32'd1 << $urandom_range(0, 31));
          if (tag == TagData) tag[0] = ~tag[0];
          csz = $urandom_range(0, 9);
          put_chunk(tag, csz);
          put_samples(csz);
        end
        dsz = $urandom_range(0, 40);
        put_chunk(TagData, dsz);
        put_samples(dsz);
        put_samples($urandom_range(0, 4));
        if (sel == 1) wav_buf[$urandom_range(0, wav_buf.size() - 1)] = 8'($urandom);
        else if (sel == 2) wav_buf = wav_buf[0:$urandom_range(0, wav_buf.size() - 1)];
      end
      rnd_bytes += wav_buf.size();
      ship();
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (words_to_send.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/wpp_pkg.sv
hdl/wpp_parser.sv
hdl/wav_pcm_parse_mono_downmix_core.sv
tb/tb_wav_pcm_parse_mono_downmix_core.sv
